/* rtl/stitched_patch_index_generator_unit_defines.svh */
`ifndef STITCHED_PATCH_INDEX_GENERATOR_UNIT_DEFINES_SVH
`define STITCHED_PATCH_INDEX_GENERATOR_UNIT_DEFINES_SVH

// Assertion helpers. Both expect clk and arst_n in the scope where they are used.

`define SPIG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SPIG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/spig_pkg.sv */
package spig_pkg;

	localparam int PATCH_QUADS_DEF = 16;
	localparam int PATCH_QUADS_MAX = 64;

	localparam int MASK_W  = 4;
	localparam int TRI_W   = 9;
	localparam int VERT_W  = 9;
	localparam int COORD_W = $clog2(PATCH_QUADS_MAX + 1);

	localparam int FAN_TRIS = 3;

	localparam logic [MASK_W-1:0] MASK_NORTH = 4'h1;
	localparam logic [MASK_W-1:0] MASK_SOUTH = 4'h2;
	localparam logic [MASK_W-1:0] MASK_EAST  = 4'h4;
	localparam logic [MASK_W-1:0] MASK_WEST  = 4'h8;

	typedef enum logic [1:0] {
		REG_NONE,
		REG_INTERIOR,
		REG_CORNER,
		REG_STRIP
	} region_t;

	typedef enum logic [1:0] {
		SIDE_NORTH,
		SIDE_SOUTH,
		SIDE_EAST,
		SIDE_WEST
	} side_t;

	typedef struct packed {
		logic             tri_ok;
		logic             last;
		region_t          region;
		side_t            side;
		logic             flagged;
		logic [TRI_W-1:0] k;
	} cls_t;

	typedef struct packed {
		cls_t             cls;
		logic [TRI_W-1:0] num;
		logic [TRI_W-1:0] quot;
	} div_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} coord_t;

	typedef struct packed {
		coord_t va;
		coord_t vb;
		coord_t vc;
	} tri3_t;

	typedef struct packed {
		tri3_t shape;
		logic  tri_ok;
		logic  last;
	} geo_t;

	function automatic tri3_t plain_tri(input coord_t org, input logic half);
		coord_t i0;
		coord_t i1;
		coord_t i2;
		coord_t i3;
		tri3_t  res;
		i0 = org;
		i1.col = org.col + COORD_W'(1);
		i1.row = org.row;
		i2.col = org.col;
		i2.row = org.row + COORD_W'(1);
		i3.col = org.col + COORD_W'(1);
		i3.row = org.row + COORD_W'(1);
		if (half) begin
			res.va = i1;
			res.vb = i2;
			res.vc = i3;
		end else begin
			res.va = i0;
			res.vb = i2;
			res.vc = i1;
		end
		return res;
	endfunction

	function automatic coord_t edge_pt(input logic [COORD_W-1:0] along,
			input logic [COORD_W-1:0] across, input logic along_col);
		coord_t res;
		if (along_col) begin
			res.col = along;
			res.row = across;
		end else begin
			res.col = across;
			res.row = along;
		end
		return res;
	endfunction

endpackage

/* rtl/spig_classify.sv */
module spig_classify #(
	parameter int PATCH_QUADS = spig_pkg::PATCH_QUADS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [spig_pkg::MASK_W-1:0]    edge_mask,
	input  logic [spig_pkg::TRI_W-1:0]     tri_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output spig_pkg::cls_t                 out_cls
);

	localparam int INNER     = PATCH_QUADS - 2;
	localparam int PAIRS     = INNER / 2;
	localparam int INT_LEN   = INNER * INNER * 2;
	localparam int PLAIN_LEN = INNER * 2;
	localparam int FAN_LEN   = PAIRS * spig_pkg::FAN_TRIS;
	localparam int TOT_MAX   = INT_LEN + 8 + 4 * PLAIN_LEN;
	localparam int BW_RAW    = $clog2(TOT_MAX + 1);
	localparam int BW        = (BW_RAW > spig_pkg::TRI_W) ? BW_RAW : spig_pkg::TRI_W;

	logic [BW-1:0]  t_w;
	logic [3:0]     flag;
	logic [BW-1:0]  slen [4];
	logic [BW-1:0]  base [5];
	logic [BW-1:0]  sel_base;
	spig_pkg::cls_t cls_d;
	spig_pkg::cls_t cls_s1;
	logic           v_s1;

	always_comb begin
		t_w = BW'(tri_number);
		flag[0] = (edge_mask & spig_pkg::MASK_NORTH) != '0;
		flag[1] = (edge_mask & spig_pkg::MASK_SOUTH) != '0;
		flag[2] = (edge_mask & spig_pkg::MASK_EAST) != '0;
		flag[3] = (edge_mask & spig_pkg::MASK_WEST) != '0;
		for (int e = 0; e < 4; e++) begin
			slen[e] = flag[e] ? BW'(FAN_LEN) : BW'(PLAIN_LEN);
		end
		base[0] = BW'(INT_LEN + 8);
		for (int e = 0; e < 4; e++) begin
			base[e + 1] = base[e] + slen[e];
		end

		cls_d = '0;
		cls_d.tri_ok = 1'b1;
		sel_base = '0;
		priority if (t_w < BW'(INT_LEN)) begin
			cls_d.region = spig_pkg::REG_INTERIOR;
		end else if (t_w < base[0]) begin
			cls_d.region = spig_pkg::REG_CORNER;
			sel_base = BW'(INT_LEN);
		end else if (t_w < base[1]) begin
			cls_d.region = spig_pkg::REG_STRIP;
			cls_d.side = spig_pkg::SIDE_NORTH;
			cls_d.flagged = flag[0];
			sel_base = base[0];
		end else if (t_w < base[2]) begin
			cls_d.region = spig_pkg::REG_STRIP;
			cls_d.side = spig_pkg::SIDE_SOUTH;
			cls_d.flagged = flag[1];
			sel_base = base[1];
		end else if (t_w < base[3]) begin
			cls_d.region = spig_pkg::REG_STRIP;
			cls_d.side = spig_pkg::SIDE_EAST;
			cls_d.flagged = flag[2];
			sel_base = base[2];
		end else if (t_w < base[4]) begin
			cls_d.region = spig_pkg::REG_STRIP;
			cls_d.side = spig_pkg::SIDE_WEST;
			cls_d.flagged = flag[3];
			sel_base = base[3];
		end else begin
			cls_d.region = spig_pkg::REG_NONE;
			cls_d.tri_ok = 1'b0;
		end
		cls_d.k = spig_pkg::TRI_W'(t_w - sel_base);
		cls_d.last = (t_w == base[4] - BW'(1));
	end

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_cls   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

/* rtl/spig_divide.sv */
module spig_divide #(
	parameter int PATCH_QUADS = spig_pkg::PATCH_QUADS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spig_pkg::cls_t in_cls,
	output logic           out_valid,
	input  logic           out_ready,
	output spig_pkg::div_t out_div
);

	localparam int INNER    = PATCH_QUADS - 2;
	localparam int DIV_SH   = 16;
	localparam int REC_W    = DIV_SH + 1;
	localparam int PROD_W   = spig_pkg::TRI_W + REC_W;
	localparam int RECIP_IN = (2 ** DIV_SH + INNER - 1) / INNER;
	localparam int RECIP_3  = (2 ** DIV_SH + spig_pkg::FAN_TRIS - 1) / spig_pkg::FAN_TRIS;

	logic                         is_fan;
	logic [spig_pkg::TRI_W-1:0]   num;
	logic [REC_W-1:0]             recip;
	logic [PROD_W-1:0]            prod;
	spig_pkg::div_t               div_d;
	spig_pkg::div_t               div_s2;
	logic                         v_s2;

	always_comb begin
		is_fan = (in_cls.region == spig_pkg::REG_STRIP) && in_cls.flagged;
		num = (in_cls.region == spig_pkg::REG_INTERIOR) ? (in_cls.k >> 1) : in_cls.k;
		recip = is_fan ? REC_W'(RECIP_3) : REC_W'(RECIP_IN);
		prod = PROD_W'(num) * PROD_W'(recip);
		div_d.cls = in_cls;
		div_d.num = num;
		div_d.quot = prod[DIV_SH +: spig_pkg::TRI_W];
	end

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;
	assign out_div   = div_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_s2 <= div_d;
		end
	end

endmodule

/* rtl/spig_coord.sv */
module spig_coord #(
	parameter int PATCH_QUADS = spig_pkg::PATCH_QUADS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spig_pkg::div_t in_div,
	output logic           out_valid,
	input  logic           out_ready,
	output spig_pkg::geo_t out_geo
);

	localparam int INNER = PATCH_QUADS - 2;
	localparam int TW    = spig_pkg::TRI_W;
	localparam int CW    = spig_pkg::COORD_W;

	localparam logic [CW-1:0] NM1 = CW'(PATCH_QUADS - 1);
	localparam logic [CW-1:0] NN  = CW'(PATCH_QUADS);

	spig_pkg::cls_t    cls;
	logic              is_fan;
	logic [TW-1:0]     dvs;
	logic [2*TW-1:0]   prod;
	logic [TW-1:0]     rem;
	logic [TW-1:0]     q_fix;
	logic              half;
	spig_pkg::coord_t  org;
	logic [CW-1:0]     qq;
	logic [CW-1:0]     s0;
	logic [CW-1:0]     s1;
	logic [CW-1:0]     s2;
	logic [CW-1:0]     fx;
	logic [CW-1:0]     qx;
	logic              along_col;
	spig_pkg::coord_t  f0;
	spig_pkg::coord_t  f1;
	spig_pkg::coord_t  f2;
	spig_pkg::coord_t  q0;
	spig_pkg::coord_t  q1;
	spig_pkg::geo_t    geo_d;
	spig_pkg::geo_t    geo_s3;
	logic              v_s3;

	always_comb begin
		cls = in_div.cls;
		is_fan = (cls.region == spig_pkg::REG_STRIP) && cls.flagged;
		dvs = is_fan ? TW'(spig_pkg::FAN_TRIS) : TW'(INNER);
		prod = (2 * TW)'(in_div.quot) * (2 * TW)'(dvs);
		rem = TW'((2 * TW)'(in_div.num) - prod);
		q_fix = in_div.quot;
		if (rem >= dvs) begin
			q_fix = in_div.quot + TW'(1);
			rem = rem - dvs;
		end
		half = cls.k[0];

		qq = CW'(cls.k[TW-1:1]) + CW'(1);
		s0 = CW'({q_fix, 1'b1});
		s1 = s0 + CW'(1);
		s2 = s0 + CW'(2);
		along_col = (cls.side == spig_pkg::SIDE_NORTH) || (cls.side == spig_pkg::SIDE_SOUTH);
		unique case (cls.side)
			spig_pkg::SIDE_NORTH: begin
				fx = NM1;
				qx = NN;
				org.col = qq;
				org.row = NM1;
			end
			spig_pkg::SIDE_SOUTH: begin
				fx = CW'(1);
				qx = '0;
				org.col = qq;
				org.row = '0;
			end
			spig_pkg::SIDE_EAST: begin
				fx = NM1;
				qx = NN;
				org.col = NM1;
				org.row = qq;
			end
			spig_pkg::SIDE_WEST: begin
				fx = CW'(1);
				qx = '0;
				org.col = '0;
				org.row = qq;
			end
		endcase
		f0 = spig_pkg::edge_pt(s0, fx, along_col);
		f1 = spig_pkg::edge_pt(s1, fx, along_col);
		f2 = spig_pkg::edge_pt(s2, fx, along_col);
		q0 = spig_pkg::edge_pt(s0, qx, along_col);
		q1 = spig_pkg::edge_pt(s2, qx, along_col);

		geo_d = '0;
		geo_d.tri_ok = cls.tri_ok;
		geo_d.last = cls.last;
		unique case (cls.region)
			spig_pkg::REG_INTERIOR: begin
				org.col = CW'(rem) + CW'(1);
				org.row = CW'(q_fix) + CW'(1);
				geo_d.shape = spig_pkg::plain_tri(org, half);
			end
			spig_pkg::REG_CORNER: begin
				org.col = cls.k[1] ? NM1 : '0;
				org.row = cls.k[2] ? NM1 : '0;
				geo_d.shape = spig_pkg::plain_tri(org, half);
			end
			spig_pkg::REG_STRIP: begin
				if (!cls.flagged) begin
					geo_d.shape = spig_pkg::plain_tri(org, half);
				end else if ((cls.side == spig_pkg::SIDE_NORTH) ||
						(cls.side == spig_pkg::SIDE_WEST)) begin
					unique case (rem[1:0])
						2'd0: geo_d.shape = '{va: f0, vb: q0, vc: f1};
						2'd1: geo_d.shape = '{va: f1, vb: q0, vc: q1};
						default: geo_d.shape = '{va: f1, vb: q1, vc: f2};
					endcase
				end else begin
					unique case (rem[1:0])
						2'd0: geo_d.shape = '{va: f0, vb: f1, vc: q0};
						2'd1: geo_d.shape = '{va: f1, vb: q1, vc: q0};
						default: geo_d.shape = '{va: f1, vb: f2, vc: q1};
					endcase
				end
			end
			spig_pkg::REG_NONE: begin
				geo_d.shape = '0;
			end
		endcase
	end

	assign in_ready  = !v_s3 || out_ready;
	assign out_valid = v_s3;
	assign out_geo   = geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			geo_s3 <= geo_d;
		end
	end

endmodule

/* rtl/spig_vertex.sv */
module spig_vertex #(
	parameter int PATCH_QUADS = spig_pkg::PATCH_QUADS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  spig_pkg::geo_t               in_geo,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spig_pkg::VERT_W-1:0]  vert_a,
	output logic [spig_pkg::VERT_W-1:0]  vert_b,
	output logic [spig_pkg::VERT_W-1:0]  vert_c,
	output logic                         tri_valid,
	output logic                         tri_last
);

	localparam int CW         = spig_pkg::COORD_W;
	localparam int IDX_W      = 2 * CW + 1;
	localparam int ROW_STRIDE = PATCH_QUADS + 1;

	logic                        v_s4;
	logic [spig_pkg::VERT_W-1:0] vert_a_s4;
	logic [spig_pkg::VERT_W-1:0] vert_b_s4;
	logic [spig_pkg::VERT_W-1:0] vert_c_s4;
	logic                        valid_s4;
	logic                        last_s4;

	function automatic logic [spig_pkg::VERT_W-1:0] vidx(input spig_pkg::coord_t p);
		logic [IDX_W-1:0] wide;
		wide = IDX_W'(p.row) * IDX_W'(ROW_STRIDE) + IDX_W'(p.col);
		return wide[spig_pkg::VERT_W-1:0];
	endfunction

	assign in_ready  = !v_s4 || out_ready;
	assign out_valid = v_s4;
	assign vert_a    = vert_a_s4;
	assign vert_b    = vert_b_s4;
	assign vert_c    = vert_c_s4;
	assign tri_valid = valid_s4;
	assign tri_last  = last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vert_a_s4 <= vidx(in_geo.shape.va);
			vert_b_s4 <= vidx(in_geo.shape.vb);
			vert_c_s4 <= vidx(in_geo.shape.vc);
			valid_s4  <= in_geo.tri_ok;
			last_s4   <= in_geo.last;
		end
	end

endmodule

/* rtl/stitched_patch_index_generator_unit.sv */
// Stages: classify, divide, coordinate build and vertex index, registered in that order;
// a word taken at the input passes through each of them before it is on the result ports.
// Throughput: one word per cycle while rsp_ready is high; each of the four register stages
// (named above) takes a new word whenever it is empty or passes its word on.
// Reset: arst_n clears only the stage valid bits; there is no clearing sweep.
`include "stitched_patch_index_generator_unit_defines.svh"

module stitched_patch_index_generator_unit #(
	parameter int PATCH_QUADS = spig_pkg::PATCH_QUADS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [spig_pkg::MASK_W-1:0]  edge_mask,
	input  logic [spig_pkg::TRI_W-1:0]   tri_number,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [spig_pkg::VERT_W-1:0]  vert_a,
	output logic [spig_pkg::VERT_W-1:0]  vert_b,
	output logic [spig_pkg::VERT_W-1:0]  vert_c,
	output logic                         tri_valid,
	output logic                         tri_last
);

	logic           cls_valid;
	logic           cls_ready;
	spig_pkg::cls_t cls;
	logic           div_valid;
	logic           div_ready;
	spig_pkg::div_t div;
	logic           geo_valid;
	logic           geo_ready;
	spig_pkg::geo_t geo;

	spig_classify #(
		.PATCH_QUADS(PATCH_QUADS)
	) u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.edge_mask (edge_mask),
		.tri_number(tri_number),
		.out_valid (cls_valid),
		.out_ready (cls_ready),
		.out_cls   (cls)
	);

	spig_divide #(
		.PATCH_QUADS(PATCH_QUADS)
	) u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cls_valid),
		.in_ready (cls_ready),
		.in_cls   (cls),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.out_div  (div)
	);

	spig_coord #(
		.PATCH_QUADS(PATCH_QUADS)
	) u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_div   (div),
		.out_valid(geo_valid),
		.out_ready(geo_ready),
		.out_geo  (geo)
	);

	spig_vertex #(
		.PATCH_QUADS(PATCH_QUADS)
	) u_vertex (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (geo_valid),
		.in_ready (geo_ready),
		.in_geo   (geo),
		.out_valid(rsp_valid),
		.out_ready(rsp_ready),
		.vert_a   (vert_a),
		.vert_b   (vert_b),
		.vert_c   (vert_c),
		.tri_valid(tri_valid),
		.tri_last (tri_last)
	);

	`SPIG_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, cls_valid, "accepted word lost")
	`SPIG_ASSERT_NOW(a_empty_out_ready, !rsp_valid, req_ready, "input stalled with output empty")
	`SPIG_ASSERT_NOW(a_none_not_ok, cls_valid && cls.region == spig_pkg::REG_NONE, !cls.tri_ok, "out of range word marked valid")
	`SPIG_ASSERT_NOW(a_last_needs_valid, rsp_valid && tri_last, tri_valid, "last set on invalid triangle")
	`SPIG_ASSERT_NOW(a_invalid_zero, rsp_valid && !tri_valid, vert_a == '0 && vert_b == '0 && vert_c == '0, "invalid triangle carries indices")

endmodule

/* verif/stitched_patch_index_generator_unit_tb.sv */
`timescale 1ns / 100ps

module stitched_patch_index_generator_unit_tb;

	localparam int PQ = spig_pkg::PATCH_QUADS_DEF;
	localparam int VERT_W = spig_pkg::VERT_W;
	localparam int MASK_W = spig_pkg::MASK_W;
	localparam int TRI_W = spig_pkg::TRI_W;
	localparam int FAN_TRIS = spig_pkg::FAN_TRIS;
	localparam logic [MASK_W-1:0] MASK_NORTH = spig_pkg::MASK_NORTH;
	localparam logic [MASK_W-1:0] MASK_SOUTH = spig_pkg::MASK_SOUTH;
	localparam logic [MASK_W-1:0] MASK_EAST = spig_pkg::MASK_EAST;
	localparam logic [MASK_W-1:0] MASK_WEST = spig_pkg::MASK_WEST;
	localparam int INNER = PQ - 2;
	localparam int PAIRS = INNER / 2;
	localparam int INTERIOR = INNER * INNER * 2;
	localparam int CORNER_TRIS = 8;
	localparam int RANDOM_WORDS = 1150;
	localparam int DRAIN_PAUSE_AT = 700;
	localparam int QUIET_FROM = 1000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 240;

	typedef struct packed {
		logic [VERT_W-1:0] va;
		logic [VERT_W-1:0] vb;
		logic [VERT_W-1:0] vc;
		logic              valid;
		logic              last;
	} facet_t;

	typedef struct {
		logic [MASK_W-1:0] mask;
		logic [TRI_W-1:0]  num;
		bit                typed;
		facet_t            want;
	} probe_t;

	localparam facet_t NO_FACET = '0;
	localparam facet_t FIRST_PLAIN = '{9'd18, 9'd35, 9'd19, 1'b1, 1'b0};
	localparam facet_t FINAL_WEST = '{9'd239, 9'd255, 9'd256, 1'b1, 1'b1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [MASK_W-1:0] edge_mask = '0;
	logic [TRI_W-1:0] tri_number = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [VERT_W-1:0] vert_a;
	logic [VERT_W-1:0] vert_b;
	logic [VERT_W-1:0] vert_c;
	logic tri_valid;
	logic tri_last;

	facet_t expected_facets[$];
	int words_sent = 0;
	int facets_checked = 0;
	int past_end_seen = 0;
	int list_ends_seen = 0;
	int failures = 0;
	bit quiet = 1'b0;
	bit hold_done = 1'b0;

	probe_t probes [25] = '{
		'{4'h0, 9'd0, 1'b1, FIRST_PLAIN},
		'{4'h0, 9'd1, 1'b0, NO_FACET},
		'{4'h0, 9'd391, 1'b0, NO_FACET},
		'{4'h0, 9'd392, 1'b0, NO_FACET},
		'{4'h0, 9'd395, 1'b0, NO_FACET},
		'{4'h0, 9'd396, 1'b0, NO_FACET},
		'{4'h0, 9'd399, 1'b0, NO_FACET},
		'{4'h0, 9'd511, 1'b1, FINAL_WEST},
		'{4'hf, 9'd483, 1'b1, FINAL_WEST},
		'{4'hf, 9'd484, 1'b1, NO_FACET},
		'{4'hf, 9'd511, 1'b1, NO_FACET},
		'{MASK_NORTH, 9'd400, 1'b0, NO_FACET},
		'{MASK_NORTH, 9'd401, 1'b0, NO_FACET},
		'{MASK_NORTH, 9'd402, 1'b0, NO_FACET},
		'{MASK_SOUTH, 9'd428, 1'b0, NO_FACET},
		'{MASK_SOUTH, 9'd429, 1'b0, NO_FACET},
		'{MASK_SOUTH, 9'd430, 1'b0, NO_FACET},
		'{MASK_EAST, 9'd456, 1'b0, NO_FACET},
		'{MASK_EAST, 9'd457, 1'b0, NO_FACET},
		'{MASK_EAST, 9'd458, 1'b0, NO_FACET},
		'{MASK_WEST, 9'd484, 1'b0, NO_FACET},
		'{MASK_WEST, 9'd485, 1'b0, NO_FACET},
		'{MASK_WEST, 9'd486, 1'b0, NO_FACET},
		'{4'h0, 9'd400, 1'b0, NO_FACET},
		'{4'hf, 9'd0, 1'b0, NO_FACET}
	};

	stitched_patch_index_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.edge_mask  (edge_mask),
		.tri_number (tri_number),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.vert_a     (vert_a),
		.vert_b     (vert_b),
		.vert_c     (vert_c),
		.tri_valid  (tri_valid),
		.tri_last   (tri_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [VERT_W-1:0] vertex_at(input int col, input int row);
		int flat;
		flat = row * (PQ + 1) + col;
		return flat[VERT_W-1:0];
	endfunction

	function automatic facet_t quad_half(input int col, input int row, input int half);
		facet_t f;
		f = NO_FACET;
		if (half == 0) begin
			f.va = vertex_at(col, row);
			f.vb = vertex_at(col, row + 1);
			f.vc = vertex_at(col + 1, row);
		end else begin
			f.va = vertex_at(col + 1, row);
			f.vb = vertex_at(col, row + 1);
			f.vc = vertex_at(col + 1, row + 1);
		end
		return f;
	endfunction

	function automatic int strip_length(input logic flagged);
		return flagged ? PAIRS * FAN_TRIS : INNER * 2;
	endfunction

	function automatic int list_length(input logic [MASK_W-1:0] mask);
		int len;
		len = INTERIOR + CORNER_TRIS;
		for (int e = 0; e < 4; e++)
			len += strip_length(mask[e]);
		return len;
	endfunction

	function automatic facet_t strip_facet(input spig_pkg::side_t sd, input logic flagged,
			input int k);
		facet_t f;
		int q;
		int j;
		int s;
		logic [VERT_W-1:0] f0, f1, f2, q0, q1;
		f = NO_FACET;
		if (!flagged) begin
			q = k / 2 + 1;
			case (sd)
				spig_pkg::SIDE_NORTH: f = quad_half(q, PQ - 1, k % 2);
				spig_pkg::SIDE_SOUTH: f = quad_half(q, 0, k % 2);
				spig_pkg::SIDE_EAST:  f = quad_half(PQ - 1, q, k % 2);
				default:              f = quad_half(0, q, k % 2);
			endcase
			return f;
		end
		j = k % FAN_TRIS;
		s = 1 + 2 * (k / FAN_TRIS);
		case (sd)
			spig_pkg::SIDE_NORTH: begin
				f0 = vertex_at(s, PQ - 1);
				f1 = vertex_at(s + 1, PQ - 1);
				f2 = vertex_at(s + 2, PQ - 1);
				q0 = vertex_at(s, PQ);
				q1 = vertex_at(s + 2, PQ);
			end
			spig_pkg::SIDE_SOUTH: begin
				f0 = vertex_at(s, 1);
				f1 = vertex_at(s + 1, 1);
				f2 = vertex_at(s + 2, 1);
				q0 = vertex_at(s, 0);
				q1 = vertex_at(s + 2, 0);
			end
			spig_pkg::SIDE_EAST: begin
				f0 = vertex_at(PQ - 1, s);
				f1 = vertex_at(PQ - 1, s + 1);
				f2 = vertex_at(PQ - 1, s + 2);
				q0 = vertex_at(PQ, s);
				q1 = vertex_at(PQ, s + 2);
			end
			default: begin
				f0 = vertex_at(1, s);
				f1 = vertex_at(1, s + 1);
				f2 = vertex_at(1, s + 2);
				q0 = vertex_at(0, s);
				q1 = vertex_at(0, s + 2);
			end
		endcase
		if (sd == spig_pkg::SIDE_NORTH || sd == spig_pkg::SIDE_WEST) begin
			if (j == 0) begin
				f.va = f0; f.vb = q0; f.vc = f1;
			end else if (j == 1) begin
				f.va = f1; f.vb = q0; f.vc = q1;
			end else begin
				f.va = f1; f.vb = q1; f.vc = f2;
			end
		end else begin
			if (j == 0) begin
				f.va = f0; f.vb = f1; f.vc = q0;
			end else if (j == 1) begin
				f.va = f1; f.vb = q1; f.vc = q0;
			end else begin
				f.va = f1; f.vb = f2; f.vc = q1;
			end
		end
		return f;
	endfunction

	function automatic facet_t patch_facet(input logic [MASK_W-1:0] mask,
			input logic [TRI_W-1:0] num);
		facet_t f;
		int t;
		int k;
		int q;
		int base;
		bit found;
		f = NO_FACET;
		t = int'(num);
		if (t < INTERIOR) begin
			q = t / 2;
			f = quad_half(1 + q % INNER, 1 + q / INNER, t % 2);
			f.valid = 1'b1;
		end else if (t < INTERIOR + CORNER_TRIS) begin
			k = t - INTERIOR;
			q = k / 2;
			f = quad_half((q & 1) ? PQ - 1 : 0, (q & 2) ? PQ - 1 : 0, k % 2);
			f.valid = 1'b1;
		end else begin
			base = INTERIOR + CORNER_TRIS;
			found = 1'b0;
			for (int e = 0; e < 4; e++) begin
				if (!found) begin
					if (t < base + strip_length(mask[e])) begin
						f = strip_facet(spig_pkg::side_t'(e), mask[e], t - base);
						f.valid = 1'b1;
						found = 1'b1;
					end else begin
						base += strip_length(mask[e]);
					end
				end
			end
		end
		f.last = f.valid && (t == list_length(mask) - 1);
		return f;
	endfunction

	task automatic send_word(input logic [MASK_W-1:0] mask, input logic [TRI_W-1:0] num,
			input bit typed, input facet_t want);
		facet_t entry;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_valid <= 1'b1;
		edge_mask <= mask;
		tri_number <= num;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		entry = typed ? want : patch_facet(mask, num);
		expected_facets = {expected_facets, entry};
		words_sent++;
	endtask

	initial begin
		forever begin
			if (!hold_done && words_sent >= HOLD_AT) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		facet_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_facets.size() == 0) begin
				$error("Result word arrived with no word outstanding.");
				failures++;
			end else begin
				want = expected_facets.pop_front();
				facets_checked++;
				if (vert_a !== want.va) begin
					$error("vert_a: expected %0d, actual %0d", want.va, vert_a);
					failures++;
				end
				if (vert_b !== want.vb) begin
					$error("vert_b: expected %0d, actual %0d", want.vb, vert_b);
					failures++;
				end
				if (vert_c !== want.vc) begin
					$error("vert_c: expected %0d, actual %0d", want.vc, vert_c);
					failures++;
				end
				if (tri_valid !== want.valid) begin
					$error("tri_valid: expected %0d, actual %0d", want.valid, tri_valid);
					failures++;
				end
				if (tri_last !== want.last) begin
					$error("tri_last: expected %0d, actual %0d", want.last, tri_last);
					failures++;
				end
				if (!want.valid)
					past_end_seen++;
				if (want.last)
					list_ends_seen++;
			end
		end
	end

	initial begin
		#4800000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [MASK_W-1:0] mask;
		logic [TRI_W-1:0] num;
		int len;
		int pick;
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (probes[i])
			send_word(probes[i].mask, probes[i].num, probes[i].typed, probes[i].want);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == DRAIN_PAUSE_AT) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (expected_facets.size() != 0)
					@(posedge clk);
			end
			if (i == QUIET_FROM)
				quiet = 1'b1;
			mask = MASK_W'($urandom_range(0, 15));
			len = list_length(mask);
			pick = $urandom_range(0, 9);
			if (pick < 7)
				num = TRI_W'($urandom_range(0, len - 1));
			else if (pick == 7)
				num = TRI_W'(len - 1 + $urandom_range(0, 512 - len));
			else
				num = TRI_W'($urandom_range(0, 511));
			send_word(mask, num, 1'b0, NO_FACET);
		end
		req_valid <= 1'b0;
		waited = 0;
		while (expected_facets.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_facets.size() != 0) begin
			$error("%0d result words never arrived.", expected_facets.size());
			failures++;
		end
		$display("Sent %0d words over all sixteen edge masks; %0d results checked.",
			words_sent, facets_checked);
		$display("Of those, %0d fell past the end of the list and %0d closed a list.",
			past_end_seen, list_ends_seen);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
